// ===== src/ptc_pkg.sv =====
// Shared types and constants for the prescaled timer counter.
package ptc_pkg;

   localparam int CLOCK_HZ = 4194304;

   localparam int STEP_W      = 6;
   localparam int COUNT_W     = 8;
   localparam int DIV_W       = 8;
   localparam int CYCLE_W     = 16;
   localparam int CTRL_W      = 3;
   localparam int RELOAD_W    = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int ENABLE_BIT  = 2;

   // Prescale periods in clock cycles; all are powers of two at this clock rate.
   localparam int PERIOD_4096   = CLOCK_HZ / 4096;
   localparam int PERIOD_262144 = CLOCK_HZ / 262144;
   localparam int PERIOD_65536  = CLOCK_HZ / 65536;
   localparam int PERIOD_16384  = CLOCK_HZ / 16384;

   localparam int SHIFT_4096   = $clog2(PERIOD_4096);
   localparam int SHIFT_262144 = $clog2(PERIOD_262144);
   localparam int SHIFT_65536  = $clog2(PERIOD_65536);
   localparam int SHIFT_16384  = $clog2(PERIOD_16384);

   // Accumulator holds less than the longest period.
   localparam int ACC_W = SHIFT_4096;
   localparam int SUM_W = ACC_W + 1;

   localparam logic [CSR_INDEX_W-1:0] REG_TIMER_CONTROL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_RELOAD_VALUE  = 1'b1;

   typedef enum logic [1:0] {
      PRESCALE_DIV4096   = 2'd0,
      PRESCALE_DIV262144 = 2'd1,
      PRESCALE_DIV65536  = 2'd2,
      PRESCALE_DIV16384  = 2'd3
   } prescale_sel_type;

   typedef struct packed {
      logic [CTRL_W-1:0]   timer_control;
      logic [RELOAD_W-1:0] reload_value;
   } ptc_cfg_type;

   typedef struct packed {
      logic                timer_irq;
      logic [DIV_W-1:0]    divider_value;
      logic [COUNT_W-1:0]  counter_value;
   } ptc_result_type;

   typedef struct packed {
      logic enabled;
      logic overflow_pending;
   } ptc_status_type;

endpackage

// ===== src/ptc_core.sv =====
// Timer state and the combinational divider/prescaler/counter update.
module ptc_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_fire,
   input  logic [ptc_pkg::STEP_W-1:0]   step_cycles,
   input  ptc_pkg::ptc_cfg_type         cfg,
   output ptc_pkg::ptc_result_type      result,
   output ptc_pkg::ptc_status_type      status
);
   import ptc_pkg::*;

   logic [CYCLE_W-1:0] cycle_total_ff, cycle_total_in;
   logic [ACC_W-1:0]   prescale_accum_ff, prescale_accum_in;
   logic [COUNT_W-1:0] timer_count_ff, timer_count_in;
   logic               overflow_pending_ff, overflow_pending_in;

   logic               enabled;
   logic [SUM_W-1:0]   accum_sum;
   logic [SUM_W-1:0]   ticks;
   logic [SUM_W-1:0]   remainder;
   logic [COUNT_W-1:0] count_base;
   logic [SUM_W:0]     count_sum;
   logic               wrap;

   assign enabled   = cfg.timer_control[ENABLE_BIT];
   assign accum_sum = {1'b0, prescale_accum_ff} + SUM_W'(step_cycles);

   // Power-of-two periods: quotient is a shift, remainder a mask.
   always_comb begin
      case (prescale_sel_type'(cfg.timer_control[1:0]))
         PRESCALE_DIV4096: begin
            ticks     = accum_sum >> SHIFT_4096;
            remainder = accum_sum & SUM_W'(PERIOD_4096 - 1);
         end
         PRESCALE_DIV262144: begin
            ticks     = accum_sum >> SHIFT_262144;
            remainder = accum_sum & SUM_W'(PERIOD_262144 - 1);
         end
         PRESCALE_DIV65536: begin
            ticks     = accum_sum >> SHIFT_65536;
            remainder = accum_sum & SUM_W'(PERIOD_65536 - 1);
         end
         PRESCALE_DIV16384: begin
            ticks     = accum_sum >> SHIFT_16384;
            remainder = accum_sum & SUM_W'(PERIOD_16384 - 1);
         end
         default: begin
            ticks     = '0;
            remainder = accum_sum;
         end
      endcase
   end

   // Pending overflow from the previous step reloads before this step counts.
   assign count_base = overflow_pending_ff ? cfg.reload_value : timer_count_ff;
   assign count_sum  = (SUM_W+1)'(count_base) + (SUM_W+1)'(ticks);
   assign wrap       = |count_sum[SUM_W:COUNT_W];

   always_comb begin
      cycle_total_in      = cycle_total_ff + CYCLE_W'(step_cycles);
      prescale_accum_in   = prescale_accum_ff;
      timer_count_in      = timer_count_ff;
      overflow_pending_in = overflow_pending_ff;
      result.timer_irq    = 1'b0;
      if (enabled) begin
         prescale_accum_in   = remainder[ACC_W-1:0];
         timer_count_in      = count_sum[COUNT_W-1:0];
         overflow_pending_in = wrap;
         result.timer_irq    = overflow_pending_ff;
      end
      result.counter_value = timer_count_in;
      result.divider_value = cycle_total_in[CYCLE_W-1 -: DIV_W];
   end

   assign status.enabled          = enabled;
   assign status.overflow_pending = overflow_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_total_ff      <= '0;
         prescale_accum_ff   <= '0;
         timer_count_ff      <= '0;
         overflow_pending_ff <= 1'b0;
      end else if (step_fire) begin
         cycle_total_ff      <= cycle_total_in;
         prescale_accum_ff   <= prescale_accum_in;
         timer_count_ff      <= timer_count_in;
         overflow_pending_ff <= overflow_pending_in;
      end
   end

endmodule

// ===== src/prescaled_timer_counter.sv =====
// Top level: stream channels, control registers, input and result registers.
// Usage:
//   Each req transaction carries the cycle count of one emulated CPU step
//   (req_tdata[5:0]). Every step returns exactly one rsp transaction with the
//   timer counter, the divider (bits 15..8 of the running cycle count) and the
//   timer interrupt flag.
//   Registers are written over the csr channel (index 0: timer control,
//   index 1: reload value); csr_ready is always high. Write them only while
//   no step is in flight.
//   An accepted step is held in the input register, then updated by the core
//   into the result register, whose valid flag drives rsp_tvalid. Throughput
//   is one step per cycle while rsp_tready stays high; the limit is the single
//   add, shift and compare path from the state registers to the result.
//   When rsp_tready is low the result holds, the input register still takes
//   one more step, and req_tready then drops until the result is taken.
//   Reset clears the cycle count, prescaler, counter, pending overflow and
//   both control registers; no step is lost or repeated across a stall.
module prescaled_timer_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] step_cycles, [7:6] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] counter_value, [15:8] divider_value,
                                    // [16] timer_irq, [23:17] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ptc_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [STEP_W-1:0]   in_cycles_ff;
   logic                out_valid_ff, out_valid_in;
   ptc_result_type      out_result_ff;
   ptc_cfg_type         cfg_ff, cfg_in;
   ptc_result_type      core_result;
   ptc_status_type      core_status;
   logic                req_fire;
   logic                advance;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TIMER_CONTROL: cfg_in.timer_control = csr_data[CTRL_W-1:0];
            REG_RELOAD_VALUE:  cfg_in.reload_value  = csr_data[RELOAD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Move the registered step into the result stage when that stage frees up.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   ptc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_fire   (advance),
      .step_cycles (in_cycles_ff),
      .cfg         (cfg_ff),
      .result      (core_result),
      .status      (core_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cycles_ff <= req_tdata[STEP_W-1:0];
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_result_ff};

   // A step moved into the result stage is presented next cycle.
   a_advance_presents: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("step advanced but no result presented");

   // Disabled timer never raises the interrupt.
   a_disabled_no_irq: assert property (@(posedge clock) disable iff (reset)
      (advance && !core_status.enabled) |=> !rsp_tdata[16])
      else $error("interrupt raised with timer disabled");

   // A pending overflow on an enabled step raises the interrupt.
   a_pending_irq: assert property (@(posedge clock) disable iff (reset)
      (advance && core_status.enabled && core_status.overflow_pending)
      |=> rsp_tdata[16])
      else $error("pending overflow did not raise interrupt");

   // Both stages full and output stalled: input must back-pressure.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline full and stalled");

endmodule
